// ===== hw/rtl/phr_pkg.sv =====
`timescale 1ns / 1ps

package phr_pkg;

  localparam logic [7:0] SLASH_CHAR = 8'h2F;
  localparam int WORDS_PER_ENTRY = 4;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_FROM_LOW  = 3'd0;
  localparam logic [2:0] REG_FROM_HIGH = 3'd1;
  localparam logic [2:0] REG_FROM_LEN  = 3'd2;
  localparam logic [2:0] REG_TO_LOW    = 3'd3;
  localparam logic [2:0] REG_TO_HIGH   = 3'd4;
  localparam logic [2:0] REG_TO_LEN    = 3'd5;

  // Output segments of one item, in emission order.
  localparam int SEG_FROM = 0;
  localparam int SEG_TO   = 1;
  localparam int SEG_PAD  = 2;
  localparam int SEG_RUN  = 3;
  localparam int SEG_HASH = 4;
  localparam int SEG_BYTE = 5;
  localparam int NUM_SEGS = 6;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_END   = 2'd1,
    OP_WRITE = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        entry_ok;
    logic [7:0]  data_byte;
    logic [5:0]  entry_index;
    logic [1:0]  word_index;
    logic [63:0] hash_word;
  } cmd_t;

  typedef struct packed {
    logic [63:0] from_low;
    logic [63:0] from_high;
    logic [63:0] to_low;
    logic [63:0] to_high;
    logic [4:0]  from_len;
    logic [4:0]  to_len;
  } cfg_t;

  function automatic logic [7:0] pick_byte(input logic [63:0] lo, input logic [63:0] hi,
                                           input logic [3:0] i);
    logic [7:0] b;
    if (i[3]) begin
      b = hi[8*i[2:0] +: 8];
    end else begin
      b = lo[8*i[2:0] +: 8];
    end
    return b;
  endfunction

endpackage

// ===== hw/rtl/phr_front.sv =====
`timescale 1ns / 1ps

module phr_front import phr_pkg::*; #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [7:0]  data_byte,
  input  logic [5:0]  entry_index,
  input  logic [1:0]  word_index,
  input  logic [63:0] hash_word,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);

  cmd_t       incoming;
  cmd_t       slots [2];
  logic [1:0] count;
  logic       wptr;
  logic       rptr;
  logic       push;
  logic       pop;

  // Decode the operation and check the table index once, on the way in.
  always_comb begin
    incoming.op          = op_t'(operation);
    incoming.entry_ok    = 32'({26'd0, entry_index}) < 32'(TABLE_ENTRIES);
    incoming.data_byte   = data_byte;
    incoming.entry_index = entry_index;
    incoming.word_index  = word_index;
    incoming.hash_word   = hash_word;
  end

  assign in_ready  = (count != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (count != 2'd0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wptr  <= 1'b0;
      rptr  <= 1'b0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= incoming;
    end
  end

endmodule

// ===== hw/rtl/phr_back.sv =====
`timescale 1ns / 1ps

module phr_back import phr_pkg::*; #(
  parameter int HASH_BYTES       = 32,
  parameter int TABLE_ENTRIES    = 64,
  parameter int SLASH_COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [15:0] repeat_count,
  output logic        last
);

  localparam int VALID_ENTRIES = (TABLE_ENTRIES < 64) ? TABLE_ENTRIES : 64;
  localparam int EW            = (VALID_ENTRIES > 1) ? $clog2(VALID_ENTRIES) : 1;
  localparam int HASH_WORDS    = (HASH_BYTES + 7) / 8;
  localparam int HIW           = (HASH_WORDS > 1) ? $clog2(HASH_WORDS) : 1;
  localparam int HFW           = $clog2(HASH_BYTES + 1);
  localparam int SB            = SLASH_COUNT_BITS;

  typedef enum logic [1:0] {ST_IDLE, ST_LOOKUP, ST_TAIL, ST_EMIT} state_t;
  typedef enum logic [1:0] {PH_MATCH, PH_SLASH, PH_HASH} phase_t;

  state_t state;
  phase_t phase;
  logic [4:0]     match_count;
  logic [SB-1:0]  slash_run;
  logic [HFW-1:0] hash_fill;
  logic [63:0]    hash_buf [2**HIW];
  logic [VALID_ENTRIES-1:0] entry_valid;
  logic [63:0]    table_mem [VALID_ENTRIES*WORDS_PER_ENTRY];

  // Lookup pipeline.
  logic [EW-1:0] lk_entry;
  logic [1:0]    lk_word;
  logic          p_valid;
  logic [EW-1:0] p_entry;
  logic [1:0]    p_word;
  logic [63:0]   mem_q;
  logic          acc;
  logic          hit;

  // Emission plan.
  logic [NUM_SEGS-1:0] pend;
  logic [4:0]     cnt_from;
  logic [4:0]     cnt_to;
  logic [4:0]     pad_rep;
  logic [SB-1:0]  run_rep;
  logic [HFW-1:0] cnt_hash;
  logic [7:0]     lone_byte;
  logic [5:0]     idx;

  // Decision signals.
  logic                dec_fire;
  logic [NUM_SEGS-1:0] dec_pend;
  logic [4:0]          dec_from_cnt;
  logic                dec_lookup;
  phase_t              nx_phase;
  logic [4:0]          nx_mc;
  logic [SB-1:0]       nx_run;
  logic [HFW-1:0]      nx_fill;
  logic                hb_we;
  logic [HFW-1:0]      hb_widx;
  logic                tbl_we;
  logic [4:0]          fl;
  logic [4:0]          tl;
  logic [7:0]          b;
  logic                adv1;
  logic                adv2;
  logic [4:0]          mc_inc;
  logic [HFW:0]        fill_inc;

  // Compare and emission signals.
  logic [HIW-1:0]      rword;
  logic [63:0]         hb_rd;
  logic [63:0]         word_mask;
  logic                eq;
  logic                cur;
  logic [NUM_SEGS-1:0] seg_hot;
  logic [NUM_SEGS-1:0] pend_after;
  logic [NUM_SEGS-1:0] tail_pend;
  logic [7:0]          em_byte;
  logic [15:0]         em_rep;
  logic [5:0]          em_cnt;
  logic                seg_done;
  logic                out_free;

  assign fl       = cfg.from_len;
  assign tl       = cfg.to_len;
  assign b        = cmd.data_byte;
  assign dec_fire = (state == ST_IDLE) && cmd_valid;
  assign cmd_pop  = dec_fire;
  assign mc_inc   = match_count + 5'd1;
  assign fill_inc = (HFW+1)'(hash_fill) + (HFW+1)'(1);
  assign adv1     = (match_count < fl) &&
                    (b == pick_byte(cfg.from_low, cfg.from_high, match_count[3:0]));
  assign adv2     = (fl != 5'd0) && (b == pick_byte(cfg.from_low, cfg.from_high, 4'd0));

  always_comb begin
    dec_pend     = '0;
    dec_from_cnt = match_count;
    dec_lookup   = 1'b0;
    nx_phase     = phase;
    nx_mc        = match_count;
    nx_run       = slash_run;
    nx_fill      = hash_fill;
    hb_we        = 1'b0;
    hb_widx      = hash_fill;
    tbl_we       = 1'b0;
    case (cmd.op)
      OP_BYTE: begin
        case (phase)
          PH_SLASH: begin
            if (b == SLASH_CHAR) begin
              if (slash_run != '1) begin
                nx_run = slash_run + SB'(1);
              end
            end else if (slash_run == '0) begin
              // Prefix without a slash: give it back and scan the byte afresh.
              dec_from_cnt       = fl;
              dec_pend[SEG_FROM] = (fl != 5'd0);
              nx_fill            = '0;
              nx_run             = '0;
              if (adv2) begin
                nx_mc    = 5'd1;
                nx_phase = (fl == 5'd1) ? PH_SLASH : PH_MATCH;
              end else begin
                nx_mc              = 5'd0;
                nx_phase           = PH_MATCH;
                dec_pend[SEG_BYTE] = 1'b1;
              end
            end else begin
              hb_we      = 1'b1;
              hb_widx    = '0;
              nx_fill    = HFW'(1);
              nx_phase   = PH_HASH;
              dec_lookup = (HASH_BYTES == 1);
            end
          end
          PH_HASH: begin
            hb_we      = 1'b1;
            nx_fill    = HFW'(fill_inc);
            dec_lookup = (fill_inc >= (HFW+1)'(HASH_BYTES));
          end
          default: begin
            if (adv1) begin
              nx_mc = mc_inc;
              if (mc_inc == fl) begin
                nx_phase = PH_SLASH;
                nx_run   = '0;
              end
            end else begin
              // Partial match: held bytes go out, the byte is scanned again.
              dec_pend[SEG_FROM] = (match_count != 5'd0);
              if (adv2) begin
                nx_mc = 5'd1;
                if (fl == 5'd1) begin
                  nx_phase = PH_SLASH;
                  nx_run   = '0;
                end
              end else begin
                nx_mc              = 5'd0;
                dec_pend[SEG_BYTE] = 1'b1;
              end
            end
          end
        endcase
      end
      OP_END: begin
        if (phase == PH_MATCH) begin
          dec_pend[SEG_FROM] = (match_count != 5'd0);
        end else begin
          dec_from_cnt       = fl;
          dec_pend[SEG_FROM] = (fl != 5'd0);
          dec_pend[SEG_RUN]  = (slash_run != '0);
          dec_pend[SEG_HASH] = (hash_fill != '0);
        end
        nx_phase = PH_MATCH;
        nx_mc    = 5'd0;
        nx_run   = '0;
        nx_fill  = '0;
      end
      OP_WRITE: begin
        tbl_we = cmd.entry_ok;
      end
      default: begin
      end
    endcase
  end

  // Hash buffer read port, shared between the table compare and the emitter.
  assign rword = (state == ST_EMIT) ? HIW'(idx >> 3) : HIW'(p_word);
  assign hb_rd = hash_buf[rword];

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      word_mask[8*j +: 8] = ((32'(p_word) * 8 + j) < HASH_BYTES) ? 8'hFF : 8'h00;
    end
  end

  assign eq  = (((mem_q ^ hb_rd) & word_mask) == 64'd0);
  assign cur = ((p_word == 2'd0) ? entry_valid[p_entry] : acc) && eq;

  // Segments to emit once the last word of the last entry has been compared.
  always_comb begin
    tail_pend = '0;
    if (hit || cur) begin
      tail_pend[SEG_TO]  = (tl != 5'd0);
      tail_pend[SEG_PAD] = (fl != tl);
    end else begin
      tail_pend[SEG_FROM] = (fl != 5'd0);
    end
    tail_pend[SEG_RUN]  = (slash_run != '0);
    tail_pend[SEG_HASH] = (hash_fill != '0);
  end

  // The current segment is the lowest one still pending.
  assign seg_hot = pend & (~pend + NUM_SEGS'(1));

  always_comb begin
    em_byte = lone_byte;
    em_rep  = 16'd1;
    em_cnt  = 6'd1;
    if (seg_hot[SEG_FROM]) begin
      em_byte = pick_byte(cfg.from_low, cfg.from_high, idx[3:0]);
      em_cnt  = 6'(cnt_from);
    end else if (seg_hot[SEG_TO]) begin
      em_byte = pick_byte(cfg.to_low, cfg.to_high, idx[3:0]);
      em_cnt  = 6'(cnt_to);
    end else if (seg_hot[SEG_PAD]) begin
      em_byte = SLASH_CHAR;
      em_rep  = 16'(pad_rep);
    end else if (seg_hot[SEG_RUN]) begin
      em_byte = SLASH_CHAR;
      em_rep  = 16'(run_rep);
    end else if (seg_hot[SEG_HASH]) begin
      em_byte = hb_rd[8*idx[2:0] +: 8];
      em_cnt  = 6'(cnt_hash);
    end
  end

  assign seg_done   = ((idx + 6'd1) == em_cnt);
  assign pend_after = seg_done ? (pend & ~seg_hot) : pend;
  assign out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= PH_MATCH;
      match_count <= 5'd0;
      slash_run   <= '0;
      hash_fill   <= '0;
      entry_valid <= '0;
      pend        <= '0;
      idx         <= 6'd0;
      p_valid     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (dec_fire) begin
            phase       <= nx_phase;
            match_count <= nx_mc;
            slash_run   <= nx_run;
            hash_fill   <= nx_fill;
            cnt_from    <= dec_from_cnt;
            lone_byte   <= b;
            run_rep     <= slash_run;
            cnt_hash    <= hash_fill;
            pend        <= dec_pend;
            idx         <= 6'd0;
            if (cmd.op == OP_CLEAR) begin
              entry_valid <= '0;
            end
            if (tbl_we) begin
              entry_valid[EW'(cmd.entry_index)] <= 1'b1;
            end
            if (dec_lookup) begin
              state    <= ST_LOOKUP;
              lk_entry <= '0;
              lk_word  <= 2'd0;
              hit      <= 1'b0;
              p_valid  <= 1'b0;
            end else if (dec_pend != '0) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_LOOKUP: begin
          p_valid <= 1'b1;
          p_entry <= lk_entry;
          p_word  <= lk_word;
          if (p_valid) begin
            acc <= cur;
            if ((p_word == 2'd3) && cur) begin
              hit <= 1'b1;
            end
          end
          if ((lk_entry == EW'(VALID_ENTRIES - 1)) && (lk_word == 2'd3)) begin
            state <= ST_TAIL;
          end else begin
            lk_word <= lk_word + 2'd1;
            if (lk_word == 2'd3) begin
              lk_entry <= lk_entry + EW'(1);
            end
          end
        end
        ST_TAIL: begin
          // The last word of the last entry is compared here.
          pend        <= tail_pend;
          cnt_from    <= fl;
          cnt_to      <= tl;
          pad_rep     <= fl - tl;
          run_rep     <= slash_run;
          cnt_hash    <= hash_fill;
          idx         <= 6'd0;
          phase       <= PH_MATCH;
          match_count <= 5'd0;
          slash_run   <= '0;
          hash_fill   <= '0;
          p_valid     <= 1'b0;
          state       <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            pend <= pend_after;
            idx  <= seg_done ? 6'd0 : idx + 6'd1;
            if (pend_after == '0) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if ((state == ST_EMIT) && out_free) begin
        out_valid    <= 1'b1;
        out_byte     <= em_byte;
        repeat_count <= em_rep;
        last         <= (pend_after == '0);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dec_fire && hb_we) begin
      hash_buf[HIW'(hb_widx >> 3)][8*hb_widx[2:0] +: 8] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_fire && tbl_we) begin
      table_mem[{EW'(cmd.entry_index), cmd.word_index}] <= cmd.hash_word;
    end
    mem_q <= table_mem[{lk_entry, lk_word}];
  end

endmodule

// ===== hw/rtl/prefix_hash_path_rewriter.sv =====
`timescale 1ns / 1ps

// Prefix hash path rewriter. Stream bytes enter one item at a time on the in
// channel; the block looks for the configured from-prefix followed by slashes
// and a hash, looks the hash up in the loaded table and emits the to-prefix on
// a hit, the original prefix on a miss. Results leave as runs: one byte value
// with a repeat count, last marking the final result of an item. Items enter a
// two-entry queue and are taken by the back end one at a time: an item that
// gives no result leaves the back end in its idle state, an item with results
// holds it until they have gone out through the output register, which stalls
// while out_ready is low. An item that completes the hash first scans the
// table, one 64-bit word per cycle from the table memory, and compares every
// word of its min(TABLE_ENTRIES, 64) entries before its up to 49 results go
// out. Table writes and table clears are done without leaving the idle state.
// Configuration registers sit at byte address 8 * index and are only to be
// written while the block is idle.
module prefix_hash_path_rewriter import phr_pkg::*; #(
  parameter int PREFIX_BYTES     = 16,
  parameter int HASH_BYTES       = 32,
  parameter int TABLE_ENTRIES    = 64,
  parameter int SLASH_COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [7:0]  data_byte,
  input  logic [5:0]  entry_index,
  input  logic [1:0]  word_index,
  input  logic [63:0] hash_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [15:0] repeat_count,
  output logic        last
);

  localparam logic [4:0] PREFIX_MAX = 5'(PREFIX_BYTES);

  logic [63:0] from_low;
  logic [63:0] from_high;
  logic [4:0]  from_length;
  logic [63:0] to_low;
  logic [63:0] to_high;
  logic [4:0]  to_length;
  logic [4:0]  eff_from;
  logic [4:0]  to_clamped;
  logic        cfg_we;
  cfg_t        cfg;
  logic        cmd_valid;
  cmd_t        cmd;
  logic        cmd_pop;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      from_low    <= 64'd0;
      from_high   <= 64'd0;
      from_length <= 5'd0;
      to_low      <= 64'd0;
      to_high     <= 64'd0;
      to_length   <= 5'd0;
    end else if (cfg_we) begin
      case (paddr[5:3])
        REG_FROM_LOW:  from_low    <= pwdata;
        REG_FROM_HIGH: from_high   <= pwdata;
        REG_FROM_LEN:  from_length <= pwdata[4:0];
        REG_TO_LOW:    to_low      <= pwdata;
        REG_TO_HIGH:   to_high     <= pwdata;
        REG_TO_LEN:    to_length   <= pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_FROM_LOW:  prdata = from_low;
      REG_FROM_HIGH: prdata = from_high;
      REG_FROM_LEN:  prdata = 64'(from_length);
      REG_TO_LOW:    prdata = to_low;
      REG_TO_HIGH:   prdata = to_high;
      REG_TO_LEN:    prdata = 64'(to_length);
      default:       prdata = 64'd0;
    endcase
  end

  // Lengths beyond the prefix storage are clamped, and the to-prefix never
  // runs longer than the from-prefix it replaces.
  assign eff_from   = (from_length > PREFIX_MAX) ? PREFIX_MAX : from_length;
  assign to_clamped = (to_length > PREFIX_MAX) ? PREFIX_MAX : to_length;

  always_comb begin
    cfg.from_low  = from_low;
    cfg.from_high = from_high;
    cfg.to_low    = to_low;
    cfg.to_high   = to_high;
    cfg.from_len  = eff_from;
    cfg.to_len    = (to_clamped > eff_from) ? eff_from : to_clamped;
  end

  phr_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .data_byte  (data_byte),
    .entry_index(entry_index),
    .word_index (word_index),
    .hash_word  (hash_word),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  phr_back #(
    .HASH_BYTES      (HASH_BYTES),
    .TABLE_ENTRIES   (TABLE_ENTRIES),
    .SLASH_COUNT_BITS(SLASH_COUNT_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .repeat_count(repeat_count),
    .last        (last)
  );

endmodule

// ===== hw/rtl/phr_checker.sv =====
`timescale 1ns / 1ps

module phr_checker import phr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic [15:0] repeat_count,
  input logic        last
);

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(repeat_count) && $stable(last))
    else $error("output item changed while stalled");

  a_rep_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> repeat_count != 16'd0)
    else $error("output run of length zero");

  // Only slash runs are folded; every other byte goes out singly.
  a_single_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_byte != SLASH_CHAR |-> repeat_count == 16'd1)
    else $error("non-slash byte with repeat count above one");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind prefix_hash_path_rewriter phr_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_byte    (out_byte),
  .repeat_count(repeat_count),
  .last        (last)
);
